### sv/protobuf_varint_field_parser_defines.svh
// Assertion macros shared by the varint field parser modules.
`ifndef PROTOBUF_VARINT_FIELD_PARSER_DEFINES_SVH
`define PROTOBUF_VARINT_FIELD_PARSER_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define PBVP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante.
`define PBVP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

// Check that expr holds at every clock edge out of reset.
`define PBVP_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error(msg);

`endif

### sv/pbvp_pkg.sv
// Types and constants of the varint field parser.
`default_nettype none

package pbvp_pkg;

	localparam int unsigned RES_FIFO_DEPTH = 4;
	localparam int unsigned RES_PTR_W      = $clog2(RES_FIFO_DEPTH);
	localparam int unsigned RES_CNT_W      = $clog2(RES_FIFO_DEPTH + 1);

	localparam logic [3:0] VARINT_MAX_BYTES = 4'd10;

	localparam logic [2:0] WT_VARINT = 3'd0;
	localparam logic [2:0] WT_LEN    = 3'd2;

	localparam logic [1:0] KIND_FIELD     = 2'd0;
	localparam logic [1:0] KIND_END_CLEAN = 2'd1;
	localparam logic [1:0] KIND_END_STOP  = 2'd2;

	typedef enum logic [2:0] {
		PH_KEY     = 3'd0,
		PH_VALUE   = 3'd1,
		PH_LENGTH  = 3'd2,
		PH_SKIP    = 3'd3,
		PH_STOPPED = 3'd4
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       final_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [31:0] field_number;
		logic [63:0] field_value;
		logic        run_end;
	} out_item_t;

	// Results produced by one parsed byte: at most two, in order.
	typedef struct packed {
		logic      first_vld;
		logic      second_vld;
		out_item_t first;
		out_item_t second;
	} res_push_t;

endpackage

`default_nettype wire

### sv/pbvp_core.sv
// Input register and byte-wise parse state of the varint field parser.
`default_nettype none
`include "protobuf_varint_field_parser_defines.svh"

module pbvp_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              byte_valid,
	output logic                   byte_ready,
	input  wire pbvp_pkg::in_item_t byte_item,
	input  wire logic              room,
	output pbvp_pkg::res_push_t    push
);

	logic               vld_s1;
	pbvp_pkg::in_item_t item_s1;
	logic               advance;

	pbvp_pkg::phase_t phase_q, phase_d;
	logic [63:0]      acc_q, acc_d;
	logic [3:0]       cnt_q, cnt_d;
	logic [31:0]      field_q, field_d;
	logic [63:0]      skip_q, skip_d;

	logic [5:0]  shamt;
	logic [63:0] acc_or;
	logic [3:0]  cnt_inc;
	logic        fld_emit;
	logic        end_clean;
	logic        fin;

	pbvp_pkg::out_item_t field_res;
	pbvp_pkg::out_item_t end_res;

	assign advance    = vld_s1 && room;
	assign byte_ready = !vld_s1 || advance;
	assign fin        = item_s1.final_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (byte_ready) begin
			vld_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid) begin
			item_s1 <= byte_item;
		end
	end

	// Place the seven payload bits at 7 * byte count; bits past 63 fall off.
	assign shamt   = 6'({3'b000, cnt_q} * 7'd7);
	assign acc_or  = acc_q | (64'(item_s1.data_byte[6:0]) << shamt);
	assign cnt_inc = cnt_q + 4'd1;

	always_comb begin
		phase_d  = phase_q;
		acc_d    = acc_q;
		cnt_d    = cnt_q;
		field_d  = field_q;
		skip_d   = skip_q;
		fld_emit = 1'b0;
		case (phase_q)
			pbvp_pkg::PH_KEY, pbvp_pkg::PH_VALUE, pbvp_pkg::PH_LENGTH: begin
				if (!item_s1.data_byte[7]) begin
					acc_d = '0;
					cnt_d = '0;
					case (phase_q)
						pbvp_pkg::PH_KEY: begin
							field_d = acc_or[34:3];
							case (acc_or[2:0])
								pbvp_pkg::WT_VARINT: phase_d = pbvp_pkg::PH_VALUE;
								pbvp_pkg::WT_LEN:    phase_d = pbvp_pkg::PH_LENGTH;
								default:             phase_d = pbvp_pkg::PH_STOPPED;
							endcase
						end
						pbvp_pkg::PH_VALUE: begin
							fld_emit = 1'b1;
							phase_d  = pbvp_pkg::PH_KEY;
						end
						default: begin
							skip_d  = acc_or;
							phase_d = (acc_or == 64'd0) ? pbvp_pkg::PH_KEY
							                            : pbvp_pkg::PH_SKIP;
						end
					endcase
				end else begin
					acc_d = acc_or;
					cnt_d = cnt_inc;
					if (cnt_inc >= pbvp_pkg::VARINT_MAX_BYTES) begin
						phase_d = pbvp_pkg::PH_STOPPED;
					end
				end
			end
			pbvp_pkg::PH_SKIP: begin
				skip_d = skip_q - 64'd1;
				if (skip_q == 64'd1) begin
					phase_d = pbvp_pkg::PH_KEY;
				end
			end
			default: begin
			end
		endcase

		end_clean = (phase_d == pbvp_pkg::PH_KEY) && (cnt_d == 4'd0);

		// Start afresh after the last byte of a message.
		if (fin) begin
			phase_d = pbvp_pkg::PH_KEY;
			acc_d   = '0;
			cnt_d   = '0;
			field_d = '0;
			skip_d  = '0;
		end
	end

	always_comb begin
		field_res.result_kind  = pbvp_pkg::KIND_FIELD;
		field_res.field_number = field_q;
		field_res.field_value  = acc_or;
		field_res.run_end      = !fin;

		end_res.result_kind  = end_clean ? pbvp_pkg::KIND_END_CLEAN : pbvp_pkg::KIND_END_STOP;
		end_res.field_number = '0;
		end_res.field_value  = '0;
		end_res.run_end      = 1'b1;

		push.first_vld  = advance && (fld_emit || fin);
		push.second_vld = advance && fld_emit && fin;
		push.first      = fld_emit ? field_res : end_res;
		push.second     = end_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= pbvp_pkg::PH_KEY;
			acc_q   <= '0;
			cnt_q   <= '0;
			field_q <= '0;
			skip_q  <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			cnt_q   <= cnt_d;
			field_q <= field_d;
			skip_q  <= skip_d;
		end
	end

	`PBVP_ASSERT_NEXT(a_final_restarts, clk, arst_n, advance && fin, (phase_q == pbvp_pkg::PH_KEY) && (cnt_q == 4'd0) && (acc_q == 64'd0), "state not cleared after last byte")
	`PBVP_ASSERT_SAME(a_second_is_end, clk, arst_n, push.second_vld, push.first_vld && (push.first.result_kind == pbvp_pkg::KIND_FIELD) && push.second.run_end, "second result not an end after a field")
	`PBVP_ASSERT_SAME(a_blocked_holds, clk, arst_n, vld_s1 && !room, !byte_ready, "byte taken while results back up")

endmodule

`default_nettype wire

### sv/pbvp_result_fifo.sv
// Small result queue: takes up to two results a cycle, gives one.
`default_nettype none
`include "protobuf_varint_field_parser_defines.svh"

module pbvp_result_fifo (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire pbvp_pkg::res_push_t  push,
	output logic                      room,
	output logic                      res_valid,
	input  wire logic                 res_ready,
	output pbvp_pkg::out_item_t       res_item
);

	pbvp_pkg::out_item_t mem_q [pbvp_pkg::RES_FIFO_DEPTH];

	logic [pbvp_pkg::RES_PTR_W-1:0] wr_ptr_q;
	logic [pbvp_pkg::RES_PTR_W-1:0] rd_ptr_q;
	logic [pbvp_pkg::RES_CNT_W-1:0] cnt_q;
	logic [pbvp_pkg::RES_PTR_W-1:0] wr_ptr_nxt;
	logic [pbvp_pkg::RES_CNT_W-1:0] n_push;
	logic                           pop;

	assign wr_ptr_nxt = wr_ptr_q + pbvp_pkg::RES_PTR_W'(1);
	assign n_push     = pbvp_pkg::RES_CNT_W'(push.first_vld) + pbvp_pkg::RES_CNT_W'(push.second_vld);
	assign res_valid  = (cnt_q != '0);
	assign pop        = res_valid && res_ready;
	assign res_item   = mem_q[rd_ptr_q];

	// Leave space for two results before taking another byte.
	assign room = (cnt_q <= pbvp_pkg::RES_CNT_W'(pbvp_pkg::RES_FIFO_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.first_vld) begin
			mem_q[wr_ptr_q] <= push.first;
		end
		if (push.second_vld) begin
			mem_q[wr_ptr_nxt] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + n_push[pbvp_pkg::RES_PTR_W-1:0];
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + pbvp_pkg::RES_PTR_W'(1);
			end
			cnt_q <= cnt_q + n_push - pbvp_pkg::RES_CNT_W'(pop);
		end
	end

	`PBVP_ASSERT_ALWAYS(a_cnt_bound, clk, arst_n, cnt_q <= pbvp_pkg::RES_CNT_W'(pbvp_pkg::RES_FIFO_DEPTH), "result queue count beyond depth")
	`PBVP_ASSERT_SAME(a_push_room, clk, arst_n, push.first_vld, room, "result pushed without room")
	`PBVP_ASSERT_NEXT(a_pop_drains, clk, arst_n, pop && !push.first_vld, cnt_q == $past(cnt_q) - pbvp_pkg::RES_CNT_W'(1), "pop did not drain one entry")

endmodule

`default_nettype wire

### sv/protobuf_varint_field_parser.sv
// Top level of the protobuf wire-format varint field parser.
//
// Input channel byte_valid / byte_ready / byte_item carries one message byte
// per transfer, with final_byte set on the last byte of a message.
// Output channel res_valid / res_ready / res_item carries result items: a
// decoded varint field (kind 0), or the end of a message, clean (kind 1) or
// after a parse stop (kind 2). run_end marks the last result of a byte.
// A byte transfer lands in an input register; once the result queue has
// room it is parsed and its results are written into a four-entry result
// queue, whose head is offered on the output channel.
// One byte is taken every cycle while the queue has room. A byte that
// completes a value varint on the last byte of a message gives two
// results; the queue absorbs that, and bytes keep flowing while at most
// one result per byte is drained each cycle.
// When the receiver stalls, the queue fills and byte_ready drops once fewer
// than two free entries remain; nothing is lost or repeated.
// Reset empties the queue and input register and puts the parser at the
// start of a message, waiting for a key.
`default_nettype none

module protobuf_varint_field_parser (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 byte_valid,
	output logic                      byte_ready,
	input  wire pbvp_pkg::in_item_t   byte_item,
	output logic                      res_valid,
	input  wire logic                 res_ready,
	output pbvp_pkg::out_item_t       res_item
);

	pbvp_pkg::res_push_t push;
	logic                room;

	// Hold the byte, advance the parse state, emit up to two results.
	pbvp_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_item  (byte_item),
		.room       (room),
		.push       (push)
	);

	// Queue results and drain them one transfer at a time.
	pbvp_result_fifo u_res_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_item  (res_item)
	);

endmodule

`default_nettype wire

### tb/varint_field_checker.sv
// Watches both channels of the varint field parser, predicts its results and compares them.
`timescale 1ns / 1ps

module varint_field_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	input  logic                byte_ready,
	input  pbvp_pkg::in_item_t  byte_item,
	input  logic                res_valid,
	input  logic                res_ready,
	input  pbvp_pkg::out_item_t res_item,
	output int                  fail_count,
	output int                  due_count
);

	pbvp_pkg::phase_t phase;
	logic [63:0]      accum;
	logic [3:0]       accum_bytes;
	logic [31:0]      field_num;
	logic [63:0]      skip_left;

	pbvp_pkg::out_item_t results_due [$];
	int                  errors = 0;

	function automatic void restart_message();
		phase       = pbvp_pkg::PH_KEY;
		accum       = '0;
		accum_bytes = '0;
		field_num   = '0;
		skip_left   = '0;
	endfunction

	function automatic void push_result(logic [1:0] kind, logic [31:0] num, logic [63:0] val,
			logic last);
		pbvp_pkg::out_item_t r;
		r.result_kind  = kind;
		r.field_number = num;
		r.field_value  = val;
		r.run_end      = last;
		results_due.push_back(r);
	endfunction

	// Advance the parse state by one byte and queue the results it causes.
	function automatic void decode_byte(pbvp_pkg::in_item_t it);
		logic [63:0] v;
		int          shift;
		logic        clean;
		case (phase)
			pbvp_pkg::PH_KEY, pbvp_pkg::PH_VALUE, pbvp_pkg::PH_LENGTH: begin
				shift = 7 * accum_bytes;
				if (shift < 64)
					accum = accum | ({57'b0, it.data_byte[6:0]} << shift);
				if (it.data_byte[7]) begin
					accum_bytes = accum_bytes + 4'd1;
					if (accum_bytes >= pbvp_pkg::VARINT_MAX_BYTES)
						phase = pbvp_pkg::PH_STOPPED;
				end else begin
					v           = accum;
					accum       = '0;
					accum_bytes = '0;
					if (phase == pbvp_pkg::PH_KEY) begin
						field_num = v[34:3];
						if (v[2:0] == pbvp_pkg::WT_VARINT)
							phase = pbvp_pkg::PH_VALUE;
						else if (v[2:0] == pbvp_pkg::WT_LEN)
							phase = pbvp_pkg::PH_LENGTH;
						else
							phase = pbvp_pkg::PH_STOPPED;
					end else if (phase == pbvp_pkg::PH_VALUE) begin
						push_result(pbvp_pkg::KIND_FIELD, field_num, v, !it.final_byte);
						phase = pbvp_pkg::PH_KEY;
					end else begin
						skip_left = v;
						if (v == 64'd0)
							phase = pbvp_pkg::PH_KEY;
						else
							phase = pbvp_pkg::PH_SKIP;
					end
				end
			end
			pbvp_pkg::PH_SKIP: begin
				skip_left = skip_left - 64'd1;
				if (skip_left == 64'd0)
					phase = pbvp_pkg::PH_KEY;
			end
			default: ;
		endcase
		if (it.final_byte) begin
			clean = (phase == pbvp_pkg::PH_KEY) && (accum_bytes == 4'd0);
			push_result(clean ? pbvp_pkg::KIND_END_CLEAN : pbvp_pkg::KIND_END_STOP, '0, '0,
				1'b1);
			restart_message();
		end
	endfunction

	function automatic int field_mismatch(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			return 1;
		end
		return 0;
	endfunction

	function automatic void check_result(pbvp_pkg::out_item_t got);
		pbvp_pkg::out_item_t want;
		if (results_due.size() == 0) begin
			$error("result with nothing expected: kind %0d field %0d value 0x%0h",
				got.result_kind, got.field_number, got.field_value);
			errors++;
			return;
		end
		want = results_due.pop_front();
		errors += field_mismatch("result_kind", want.result_kind, got.result_kind);
		errors += field_mismatch("field_number", want.field_number, got.field_number);
		errors += field_mismatch("field_value", want.field_value, got.field_value);
		errors += field_mismatch("run_end", want.run_end, got.run_end);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart_message();
			results_due.delete();
			fail_count <= errors;
			due_count  <= 0;
		end else begin
			if (res_valid && res_ready)
				check_result(res_item);
			if (byte_valid && byte_ready)
				decode_byte(byte_item);
			fail_count <= errors;
			due_count  <= results_due.size();
		end
	end

endmodule

### tb/tb.sv
// Top of the varint field parser testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;

	// Directed opening, each entry {final_byte, data_byte}:
	//  lone key byte that is also the last byte (key with no value),
	//  field 1 = 150 ending on the value byte (two results),
	//  zero-length skip ending the message, two-byte skip ending exactly on the last byte,
	//  unknown wire type with trailing bytes ignored, end inside a value varint,
	//  ten-byte value of all ones whose last byte carries bits past bit 63.
	localparam logic [8:0] OPENING_BYTES [26] = '{
		9'h100,
		9'h008, 9'h096, 9'h101,
		9'h012, 9'h100,
		9'h01A, 9'h002, 9'h0AA, 9'h1BB,
		9'h00B, 9'h055, 9'h166,
		9'h008, 9'h180,
		9'h008, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF,
		9'h17F
	};

	localparam int BYTES_PER_PHASE = 600;

	logic                clk        = 1'b0;
	logic                arst_n     = 1'b0;
	logic                byte_valid = 1'b0;
	logic                byte_ready;
	pbvp_pkg::in_item_t  byte_item  = '0;
	logic                res_valid;
	logic                res_ready  = 1'b0;
	pbvp_pkg::out_item_t res_item;

	int        fail_count;
	int        due_count;

	// Percent of cycles in which the sender holds off, and the receiver stalls.
	int        send_gap_pct = 0;
	int        stall_pct    = 0;

	logic [7:0] msg_bytes [$];

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	protobuf_varint_field_parser DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_item  (byte_item),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_item   (res_item)
	);

	varint_field_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_item  (byte_item),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_item   (res_item),
		.fail_count (fail_count),
		.due_count  (due_count)
	);

	// Receiver: drop ready at random, one fresh decision per cycle.
	always @(posedge clk)
		res_ready <= ($urandom_range(99) >= stall_pct);

	// Offer one byte, with a random hold-off first, and hold it until the transfer.
	task automatic send_byte(input logic [7:0] b, input logic fin);
		pbvp_pkg::in_item_t it;
		while ($urandom_range(99) < send_gap_pct) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		it.data_byte  = b;
		it.final_byte = fin;
		byte_valid <= 1'b1;
		byte_item  <= it;
		do
			@(posedge clk);
		while (!byte_ready);
	endtask

	task automatic send_message();
		for (int i = 0; i < msg_bytes.size(); i++)
			send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
	endtask

	// Lower valid and hold until every predicted result has been drained.
	task automatic drain_results();
		byte_valid <= 1'b0;
		@(posedge clk);
		while (due_count != 0)
			@(posedge clk);
	endtask

	// Append a varint of v, stretched with zero-payload continuation bytes to
	// at least min_len bytes. A tenth byte may carry junk in the bits that land
	// past bit 63, which the parser must drop.
	function automatic void push_varint(logic [63:0] v, int min_len);
		int          n;
		logic [63:0] t;
		logic [7:0]  b;
		n = 1;
		t = v >> 7;
		while (t != 64'd0) begin
			n++;
			t = t >> 7;
		end
		if (min_len > n)
			n = min_len;
		for (int i = 0; i < n; i++) begin
			t = v >> (7 * i);
			b = {(i < n - 1), t[6:0]};
			if (i == 9 && $urandom_range(1) == 1)
				b[6:1] = 6'($urandom);
			msg_bytes.push_back(b);
		end
	endfunction

	function automatic int pad_len();
		return ($urandom_range(99) < 15) ? $urandom_range(1, 10) : 1;
	endfunction

	// Mostly small field numbers, some wide ones, some that overflow 32 bits.
	function automatic logic [60:0] rand_field_num();
		int unsigned r;
		logic [63:0] w;
		r = $urandom_range(99);
		w = {$urandom, $urandom};
		if (r < 60)
			return 61'($urandom_range(1, 15));
		else if (r < 85)
			return 61'($urandom_range(16, 32'h1FFF_FFFF));
		return w[60:0];
	endfunction

	function automatic logic [63:0] rand_value();
		int          w;
		logic [63:0] v;
		if ($urandom_range(19) == 0)
			return '1;
		w = $urandom_range(0, 64);
		v = {$urandom, $urandom};
		if (w < 64)
			v = v & ((64'd1 << w) - 64'd1);
		return v;
	endfunction

	function automatic void push_noise(int n);
		repeat (n)
			msg_bytes.push_back(8'($urandom));
	endfunction

	// Build one message: mostly well-formed fields with random content, plus
	// unknown wire types, runaway varints, endless skips, noise and truncation.
	function automatic void build_message();
		int          n_fields;
		int          r;
		int          len;
		logic [2:0]  wt;
		logic [63:0] huge;
		msg_bytes.delete();
		n_fields = $urandom_range(1, 4);
		repeat (n_fields) begin
			r = $urandom_range(99);
			if (r < 45) begin
				push_varint({rand_field_num(), pbvp_pkg::WT_VARINT}, pad_len());
				push_varint(rand_value(), pad_len());
			end else if (r < 75) begin
				push_varint({rand_field_num(), pbvp_pkg::WT_LEN}, pad_len());
				len = ($urandom_range(9) == 0) ? $urandom_range(6, 20) : $urandom_range(0, 5);
				push_varint(64'(len), pad_len());
				push_noise(len);
			end else if (r < 82) begin
				wt = 3'($urandom_range(1, 7));
				if (wt == pbvp_pkg::WT_LEN)
					wt = pbvp_pkg::WT_LEN + 3'd1;
				push_varint({rand_field_num(), wt}, pad_len());
				push_noise($urandom_range(0, 3));
			end else if (r < 87) begin
				if ($urandom_range(1) == 1)
					push_varint({rand_field_num(), pbvp_pkg::WT_VARINT}, 1);
				repeat (pbvp_pkg::VARINT_MAX_BYTES)
					msg_bytes.push_back(8'h80 | 8'($urandom));
			end else if (r < 92) begin
				push_varint({rand_field_num(), pbvp_pkg::WT_LEN}, 1);
				huge = {$urandom, $urandom} | 64'h100_0000_0000;
				push_varint(huge, 1);
				push_noise($urandom_range(0, 3));
			end else begin
				push_noise($urandom_range(1, 4));
			end
		end
		if (msg_bytes.size() > 1 && $urandom_range(99) < 10) begin
			len = $urandom_range(1, msg_bytes.size() - 1);
			repeat (len)
				void'(msg_bytes.pop_back());
		end
	endfunction

	initial begin
		int sent;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int p = 0; p < 3; p++) begin
			case (p)
				0: begin
					send_gap_pct = 24;
					stall_pct    = 48;
				end
				1: begin
					send_gap_pct = 48;
					stall_pct    = 24;
				end
				default: begin
					send_gap_pct = 0;
					stall_pct    = 0;
				end
			endcase
			if (p == 0)
				for (int i = 0; i < $size(OPENING_BYTES); i++)
					send_byte(OPENING_BYTES[i][7:0], OPENING_BYTES[i][8]);
			sent = 0;
			while (sent < BYTES_PER_PHASE) begin
				build_message();
				send_message();
				sent += msg_bytes.size();
			end
			// Hold the sender off until the parser has handed over everything.
			drain_results();
		end

		repeat (10) @(posedge clk);
		if (fail_count == 0 && due_count == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#5_000_000;
		$display("tb NOT OK");
		$finish;
	end

endmodule

### protobuf_varint_field_parser.f
+incdir+sv
sv/pbvp_pkg.sv
sv/pbvp_core.sv
sv/pbvp_result_fifo.sv
sv/protobuf_varint_field_parser.sv
tb/varint_field_checker.sv
tb/tb.sv
